// ===== sv/ped_pkg.sv =====
// ============================================================================
// ped_pkg: shared types and constants for the pairwise Euclidean distance
// Beat layouts, accumulator and root widths, and the queue entry format.
// ============================================================================
`default_nettype none

package ped_pkg;

    localparam int VLEN_W     = 11;
    localparam int COORD_W    = 16;
    localparam int MAG_W      = 16;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int ACC_W      = 48;
    localparam int DIST_W     = 24;
    localparam int SQRT_STEPS = ACC_W / 2;

    localparam logic [ACC_W-1:0] ACC_MAX  = {ACC_W{1'b1}};
    localparam logic [ACC_W-1:0] SQRT_TOP = ACC_W'(1) << (ACC_W - 2);

    typedef struct packed {
        logic signed [COORD_W-1:0] a_value;
        logic signed [COORD_W-1:0] b_value;
        logic                      tile_end;
    } in_beat_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              tile_end_out;
        logic              saturated;
    } out_beat_t;

    typedef struct packed {
        logic [ACC_W-1:0] sum;
        logic             tile_end;
        logic             saturated;
    } job_t;

    typedef struct packed {
        logic busy;
        logic holding;
    } sqrt_stat_t;

endpackage

`default_nettype wire

// ===== sv/pairwise_euclidean_distance.sv =====
// ============================================================================
// pairwise_euclidean_distance: streamed Euclidean distance of vector pairs
// Accumulates squared Q8.8 coordinate differences and emits the Q16.8 floor
// square root of each vector pair's sum.
// ============================================================================
//  channel   direction  handshake              payload
//  cfg       in         cfg_wr_en              cfg_wr_data (vector_length)
//  in        in         in_valid / in_ready    in_beat_t
//  out       out        out_valid / out_ready  out_beat_t
//
//  The front end takes one coordinate beat per cycle unless a finished sum
//  waits on a full queue. Each distance takes the root unit through a load,
//  24 iterations of a shared 48-bit compare/subtract and a hand-off, and the
//  root unit takes no new sum until it has handed off the last one.
//  A queue of QUEUE_DEPTH sums buffers bursts of short vectors; when it is
//  full the front end stalls on the last beat of a vector.
//  Reset clears the accumulator and count; vector_length resets to 1.
// ============================================================================
`default_nettype none

module pairwise_euclidean_distance
    import ped_pkg::*;
#(
    parameter int MAX_DIM     = 1024,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [VLEN_W-1:0] cfg_wr_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire in_beat_t          in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output out_beat_t              out_data
);

    logic       push_valid;
    logic       push_ready;
    job_t       push_data;
    logic       job_valid;
    logic       job_ready;
    job_t       job_data;
    sqrt_stat_t sqrt_stat;

    ped_front #(
        .MAX_DIM(MAX_DIM)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    ped_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data (push_data),
        .pop_valid (job_valid),
        .pop_ready (job_ready),
        .pop_data  (job_data)
    );

    ped_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_valid(job_valid),
        .job_ready(job_ready),
        .job_data (job_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .stat     (sqrt_stat)
    );

    // no beat taken while the finished sum is blocked on a full queue
    a_stall_blocks_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> !(push_valid && !push_ready))
        else $error("input beat accepted while front end is stalled");

    // a new distance only appears from the hold state of the root unit
    a_out_from_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(sqrt_stat.holding))
        else $error("distance presented without a completed root");

    // the root unit only picks up a job when idle
    a_pop_when_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        (job_valid && job_ready) |=> (sqrt_stat.busy && !sqrt_stat.holding))
        else $error("root unit did not start after taking a job");

endmodule

`default_nettype wire

// ===== sv/ped_front.sv =====
// ============================================================================
// ped_front: coordinate front end
// Squares the coordinate difference, accumulates with saturation, counts
// elements and pushes the finished sum of each vector pair to the queue.
// ============================================================================
`default_nettype none

module ped_front
    import ped_pkg::*;
#(
    parameter int MAX_DIM = 1024
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [VLEN_W-1:0] cfg_wr_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire in_beat_t          in_data,
    output logic                   push_valid,
    input  wire logic              push_ready,
    output job_t                   push_data
);

    localparam int CNT_W = $clog2(MAX_DIM + 1);
    localparam int CMP_W = ((CNT_W > VLEN_W) ? CNT_W : VLEN_W) + 1;

    logic [VLEN_W-1:0] vector_length_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              s1_valid_reg;
    logic [SQ_W-1:0]   s1_sq_reg;
    logic              s1_final_reg;
    logic              s1_tile_reg;
    logic [ACC_W-1:0]  sum_reg;
    logic              ovf_reg;

    logic                  accept;
    logic                  s1_adv;
    logic [CMP_W-1:0]      len_raw;
    logic [CMP_W-1:0]      len_eff;
    logic                  is_final;
    logic signed [COORD_W:0] diff;
    logic [MAG_W-1:0]      mag;
    logic [ACC_W:0]        sum_wide;
    logic [ACC_W-1:0]      sum_next;
    logic                  ovf_next;

    always_comb
    begin
        len_raw = CMP_W'(vector_length_reg);
        priority if (len_raw == '0)
        begin
            len_eff = CMP_W'(1);
        end
        else if (len_raw > CMP_W'(MAX_DIM))
        begin
            len_eff = CMP_W'(MAX_DIM);
        end
        else
        begin
            len_eff = len_raw;
        end
        is_final = (CMP_W'(count_reg) + CMP_W'(1)) >= len_eff;
    end

    always_comb
    begin
        diff = (COORD_W+1)'(in_data.a_value) - (COORD_W+1)'(in_data.b_value);
        mag  = diff[COORD_W] ? MAG_W'(-diff) : MAG_W'(diff);
    end

    always_comb
    begin
        sum_wide = {1'b0, sum_reg} + (ACC_W+1)'(s1_sq_reg);
        sum_next = sum_wide[ACC_W] ? ACC_MAX : sum_wide[ACC_W-1:0];
        ovf_next = ovf_reg | sum_wide[ACC_W];
    end

    assign s1_adv     = s1_valid_reg && !(s1_final_reg && !push_ready);
    assign in_ready   = !s1_valid_reg || s1_adv;
    assign accept     = in_valid && in_ready;
    assign push_valid = s1_valid_reg && s1_final_reg;

    always_comb
    begin
        push_data.sum       = sum_next;
        push_data.tile_end  = s1_tile_reg;
        push_data.saturated = ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vector_length_reg <= VLEN_W'(1);
            count_reg         <= '0;
            s1_valid_reg      <= 1'b0;
            s1_sq_reg         <= '0;
            s1_final_reg      <= 1'b0;
            s1_tile_reg       <= 1'b0;
            sum_reg           <= '0;
            ovf_reg           <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                vector_length_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                count_reg    <= is_final ? '0 : count_reg + CNT_W'(1);
                s1_sq_reg    <= SQ_W'(mag) * SQ_W'(mag);
                s1_final_reg <= is_final;
                s1_tile_reg  <= in_data.tile_end;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                if (s1_final_reg)
                begin
                    sum_reg <= '0;
                    ovf_reg <= 1'b0;
                end
                else
                begin
                    sum_reg <= sum_next;
                    ovf_reg <= ovf_next;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/ped_fifo.sv =====
// ============================================================================
// ped_fifo: job queue
// Small register queue of finished sums between the front and the root unit.
// ============================================================================
`default_nettype none

module ped_fifo
    import ped_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire job_t push_data,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output job_t      pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/ped_sqrt.sv =====
// ============================================================================
// ped_sqrt: iterative floor square root back end
// Takes one queued sum, retires two radicand bits per cycle, and holds the
// distance in an output register until the beat is taken.
// ============================================================================
`default_nettype none

module ped_sqrt
    import ped_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  job_valid,
    output logic       job_ready,
    input  wire job_t  job_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output out_beat_t  out_data,
    output sqrt_stat_t stat
);

    localparam int STEP_W = $clog2(SQRT_STEPS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } state_t;

    state_t            state_reg;
    logic [ACC_W-1:0]  x_reg;
    logic [ACC_W-1:0]  root_reg;
    logic [ACC_W-1:0]  bit_reg;
    logic [STEP_W-1:0] step_reg;
    logic              tile_reg;
    logic              sat_reg;
    logic              out_valid_reg;
    out_beat_t         out_data_reg;

    logic [ACC_W-1:0] trial;
    logic             take;
    logic [ACC_W-1:0] x_next;
    logic [ACC_W-1:0] root_next;
    logic             load_out;

    always_comb
    begin
        trial     = root_reg + bit_reg;
        take      = x_reg >= trial;
        x_next    = take ? x_reg - trial : x_reg;
        root_next = take ? (root_reg >> 1) + bit_reg : root_reg >> 1;
    end

    assign load_out     = (state_reg == S_HOLD) && (!out_valid_reg || out_ready);
    assign job_ready    = state_reg == S_IDLE;
    assign out_valid    = out_valid_reg;
    assign out_data     = out_data_reg;
    assign stat.busy    = state_reg != S_IDLE;
    assign stat.holding = state_reg == S_HOLD;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            x_reg         <= '0;
            root_reg      <= '0;
            bit_reg       <= '0;
            step_reg      <= '0;
            tile_reg      <= 1'b0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        x_reg     <= job_data.sum;
                        root_reg  <= '0;
                        bit_reg   <= SQRT_TOP;
                        step_reg  <= '0;
                        tile_reg  <= job_data.tile_end;
                        sat_reg   <= job_data.saturated;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    x_reg    <= x_next;
                    root_reg <= root_next;
                    bit_reg  <= bit_reg >> 2;
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(SQRT_STEPS - 1))
                    begin
                        state_reg <= S_HOLD;
                    end
                end
                S_HOLD:
                begin
                    if (load_out)
                    begin
                        out_data_reg.distance     <= root_reg[DIST_W-1:0];
                        out_data_reg.tile_end_out <= tile_reg;
                        out_data_reg.saturated    <= sat_reg;
                        state_reg                 <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
